// ===== hdl/cfa_pkg.sv =====
`default_nettype none
package cfa_pkg;
   localparam int MAX_FRAMES_DEF = 1024;
   localparam int FRAME_W = 20;
   localparam int CNT_W = 11;
   localparam int STAT_W = 3;

   typedef enum logic [1:0] {
      CMD_INIT = 2'd0,
      CMD_ALLOC = 2'd1,
      CMD_RELEASE = 2'd2,
      CMD_MARK = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      FS_ALLOC = 2'd0,
      FS_INACC = 2'd1,
      FS_HEAD = 2'd2,
      FS_FREE = 2'd3
   } fstat_type;

   localparam logic [STAT_W-1:0] ST_OK = 3'd0;
   localparam logic [STAT_W-1:0] ST_NO_RUN = 3'd1;
   localparam logic [STAT_W-1:0] ST_NOT_HEAD = 3'd2;
   localparam logic [STAT_W-1:0] ST_OUTSIDE = 3'd3;
   localparam logic [STAT_W-1:0] ST_ZERO = 3'd4;

   localparam logic [1:0] CSR_BASE = 2'd0;
   localparam logic [1:0] CSR_FRAMES = 2'd1;
   localparam logic [1:0] CSR_RESERVED = 2'd2;
endpackage
`default_nettype wire

// ===== hdl/contiguous_frame_allocator.sv =====
`default_nettype none
// Contiguous frame allocator, one pool of frames, 2-bit status per frame.
// Input channel req_: one word is one command (init, allocate a first-fit
// run, release a run from its head frame, mark a range inaccessible).
// Result channel rsp_: exactly one word per command, with start frame,
// status code, free count after the command and frames handled.
// Configuration: csr_we/csr_addr/csr_wdata write pool_base (0),
// pool_frames (1), reserved_frames (2); write only while idle.
// Operation: commands run one at a time through a sequencer that visits the
// status memory one frame per cycle (one read port, one write port). Init
// sweeps the whole memory, allocate scans for a free run and then writes
// back the run, release and mark walk the run. req_tready is low while a
// command is in work.
// Reset: a clearing pass runs the init command with the reset register
// values (frame 0 allocated, rest free) and sends no result; no command is
// taken meanwhile. Stall: the result waits in the output register; the next
// command is taken only after the result has been taken.
module contiguous_frame_allocator #(
   parameter int MAX_FRAMES = cfa_pkg::MAX_FRAMES_DEF
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // [1:0] cmd, [21:2] frame_no, [32:22] count, [39:33] zero
   input  wire  [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // [19:0] start_frame, [22:20] status, [33:23] free_frames,
   // [44:34] frames_done, [47:45] zero
   output logic [47:0] rsp_tdata,
   input  wire         csr_we,
   input  wire  [1:0]  csr_addr,
   input  wire  [19:0] csr_wdata
);
   localparam int AW = $clog2(MAX_FRAMES);
   localparam int IW = AW + 1;
   localparam int FW = cfa_pkg::FRAME_W;
   localparam int CW = cfa_pkg::CNT_W;
   localparam int PW = (IW > CW) ? IW : CW;

   typedef enum logic [2:0] {
      S_INIT, S_IDLE, S_SCAN, S_FILL, S_REL, S_MARK, S_RESP
   } state_type;

   logic [1:0] mem [MAX_FRAMES];
   logic [1:0] rd_ff;

   state_type  state_ff;
   logic [FW-1:0] base_ff;
   logic [CW-1:0] pframes_ff, resv_ff;
   logic [IW-1:0] idx_ff;      // frame being read / written
   logic [IW-1:0] first_ff;
   logic [CW-1:0] run_ff;
   logic [IW-1:0] end_ff;
   logic          rvalid_ff;   // rd_ff holds frame idx_ff-1
   logic [CW-1:0] cnt_ff;
   logic [FW-1:0] fno_ff;
   logic [CW-1:0] free_ff;
   logic [CW-1:0] done_ff;
   logic [FW-1:0] start_ff;
   logic [2:0]    status_ff;
   logic          rvld_ff;
   logic          init_rsp_ff; // init came from a command word, so answer it

   logic          we;
   logic [AW-1:0] waddr;
   logic [1:0]    wdata;

   // effective pool size and clipped reserve
   logic [IW-1:0] psize, rclip;
   always_comb begin
      psize = (PW'(pframes_ff) > PW'(MAX_FRAMES)) ? IW'(MAX_FRAMES) : IW'(pframes_ff);
      rclip = (PW'(resv_ff) > PW'(psize)) ? psize : IW'(resv_ff);
   end

   wire [1:0]    in_cmd  = req_tdata[1:0];
   wire [FW-1:0] in_fno  = req_tdata[21:2];
   wire [CW-1:0] in_cnt  = req_tdata[32:22];
   wire [FW:0]   off_w   = {1'b0, in_fno} - {1'b0, base_ff};
   wire          in_pool = !off_w[FW] && (off_w < (FW+1)'(psize));

   assign req_tready = (state_ff == S_IDLE) && !rvld_ff;
   assign rsp_tvalid = rvld_ff;
   assign rsp_tdata  = {3'b0, done_ff, free_ff, status_ff, start_ff};

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[idx_ff[AW-1:0]];
   end

   always_comb begin
      we = 1'b0;
      waddr = idx_ff[AW-1:0];
      wdata = cfa_pkg::FS_FREE;
      unique case (state_ff)
         S_INIT: begin
            we = 1'b1;
            wdata = (idx_ff < rclip) ? cfa_pkg::FS_ALLOC : cfa_pkg::FS_FREE;
         end
         S_FILL: begin
            we = 1'b1;
            wdata = (idx_ff == first_ff) ? cfa_pkg::FS_HEAD : cfa_pkg::FS_ALLOC;
         end
         S_REL: begin
            waddr = AW'(idx_ff - IW'(1));
            we = rvalid_ff && ((first_ff == idx_ff - IW'(1))
                  ? (rd_ff == cfa_pkg::FS_HEAD) : (rd_ff == cfa_pkg::FS_ALLOC));
         end
         S_MARK: begin
            waddr = AW'(idx_ff - IW'(1));
            we = rvalid_ff;
            wdata = cfa_pkg::FS_INACC;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_INIT;
         base_ff     <= '0;
         pframes_ff  <= CW'(1024);
         resv_ff     <= CW'(1);
         idx_ff      <= '0;
         rvld_ff     <= 1'b0;
         rvalid_ff   <= 1'b0;
         free_ff     <= '0;
         done_ff     <= '0;
         start_ff    <= '0;
         status_ff   <= '0;
         init_rsp_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               cfa_pkg::CSR_BASE:     base_ff <= csr_wdata;
               cfa_pkg::CSR_FRAMES:   pframes_ff <= csr_wdata[CW-1:0];
               cfa_pkg::CSR_RESERVED: resv_ff <= csr_wdata[CW-1:0];
               default: ;
            endcase
         end
         if (rvld_ff && rsp_tready) rvld_ff <= 1'b0;
         unique case (state_ff)
            S_INIT: begin
               // sweep the whole memory, then set the init result (sent only for an init command)
               idx_ff <= idx_ff + IW'(1);
               if (idx_ff == IW'(MAX_FRAMES - 1)) begin
                  free_ff   <= CW'(psize - rclip);
                  done_ff   <= CW'(rclip);
                  start_ff  <= (rclip != '0) ? base_ff : '0;
                  status_ff <= cfa_pkg::ST_OK;
                  state_ff  <= init_rsp_ff ? S_RESP : S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_tvalid && req_tready) begin
                  cnt_ff <= in_cnt;
                  fno_ff <= in_fno;
                  done_ff <= '0;
                  start_ff <= '0;
                  status_ff <= cfa_pkg::ST_OK;
                  rvalid_ff <= 1'b0;
                  run_ff <= '0;
                  unique case (cfa_pkg::cmd_type'(in_cmd))
                     cfa_pkg::CMD_INIT: begin
                        idx_ff <= '0;
                        init_rsp_ff <= 1'b1;
                        state_ff <= S_INIT;
                     end
                     cfa_pkg::CMD_ALLOC: begin
                        idx_ff <= '0;
                        if (in_cnt == '0) begin
                           status_ff <= cfa_pkg::ST_ZERO;
                           state_ff <= S_RESP;
                        end else state_ff <= S_SCAN;
                     end
                     default: begin
                        idx_ff <= IW'(off_w);
                        first_ff <= IW'(off_w);
                        end_ff <= ({1'b0, off_w} + (FW+2)'(in_cnt) >
                                   (FW+2)'(psize)) ? psize
                                   : IW'(off_w + (FW+1)'(in_cnt));
                        if (in_cmd == cfa_pkg::CMD_MARK && in_cnt == '0) begin
                           status_ff <= cfa_pkg::ST_ZERO;
                           state_ff <= S_RESP;
                        end else if (!in_pool) begin
                           status_ff <= cfa_pkg::ST_OUTSIDE;
                           state_ff <= S_RESP;
                        end else if (in_cmd == cfa_pkg::CMD_RELEASE)
                           state_ff <= S_REL;
                        else state_ff <= S_MARK;
                     end
                  endcase
               end
            end
            S_SCAN: begin
               // rd_ff holds frame idx_ff-1 once rvalid_ff is set
               rvalid_ff <= 1'b1;
               if (rvalid_ff) begin
                  if (rd_ff == cfa_pkg::FS_FREE) begin
                     if (run_ff == '0) first_ff <= idx_ff - IW'(1);
                     run_ff <= run_ff + CW'(1);
                     if (run_ff + CW'(1) == cnt_ff) begin
                        idx_ff <= (run_ff == '0) ? idx_ff - IW'(1) : first_ff;
                        state_ff <= S_FILL;
                     end
                  end else run_ff <= '0;
               end
               if (state_ff == S_SCAN && !(rvalid_ff && rd_ff == cfa_pkg::FS_FREE
                   && run_ff + CW'(1) == cnt_ff)) begin
                  if (idx_ff >= psize) begin
                     status_ff <= cfa_pkg::ST_NO_RUN;
                     state_ff <= S_RESP;
                  end else idx_ff <= idx_ff + IW'(1);
               end
            end
            S_FILL: begin
               idx_ff <= idx_ff + IW'(1);
               if ({1'b0, idx_ff} + (CW+IW)'(1) == (CW+IW)'(first_ff) + (CW+IW)'(cnt_ff))
               begin
                  free_ff  <= (free_ff > cnt_ff) ? free_ff - cnt_ff : '0;
                  done_ff  <= cnt_ff;
                  start_ff <= base_ff + FW'(first_ff);
                  state_ff <= S_RESP;
               end
            end
            S_REL: begin
               rvalid_ff <= 1'b1;
               if (!rvalid_ff) idx_ff <= idx_ff + IW'(1);
               else if (first_ff == idx_ff - IW'(1)) begin
                  if (rd_ff != cfa_pkg::FS_HEAD) begin
                     status_ff <= cfa_pkg::ST_NOT_HEAD;
                     state_ff <= S_RESP;
                  end else begin
                     done_ff <= CW'(1);
                     if (idx_ff >= psize) state_ff <= S_RESP;
                     else idx_ff <= idx_ff + IW'(1);
                  end
               end else if (rd_ff == cfa_pkg::FS_ALLOC) begin
                  done_ff <= done_ff + CW'(1);
                  if (idx_ff >= psize) state_ff <= S_RESP;
                  else idx_ff <= idx_ff + IW'(1);
               end else state_ff <= S_RESP;
               // fix counts and start on leaving
               if (rvalid_ff && state_ff == S_REL) begin
                  if ((first_ff == idx_ff - IW'(1) && rd_ff == cfa_pkg::FS_HEAD
                       && idx_ff >= psize)
                      || (first_ff != idx_ff - IW'(1) && rd_ff == cfa_pkg::FS_ALLOC
                       && idx_ff >= psize)) begin
                     free_ff <= free_ff + done_ff + CW'(1);
                     start_ff <= fno_ff;
                  end else if (first_ff != idx_ff - IW'(1)
                               && rd_ff != cfa_pkg::FS_ALLOC) begin
                     free_ff <= free_ff + done_ff;
                     start_ff <= fno_ff;
                  end
               end
            end
            S_MARK: begin
               rvalid_ff <= 1'b1;
               if (rvalid_ff) begin
                  if (rd_ff == cfa_pkg::FS_FREE && free_ff != '0)
                     free_ff <= free_ff - CW'(1);
                  done_ff <= done_ff + CW'(1);
               end
               if (idx_ff >= end_ff) begin
                  if (rvalid_ff || idx_ff == first_ff) begin
                     start_ff <= fno_ff;
                     state_ff <= S_RESP;
                  end
               end else idx_ff <= idx_ff + IW'(1);
               if (idx_ff >= end_ff && !rvalid_ff && idx_ff != first_ff)
                  state_ff <= S_RESP;
            end
            S_RESP: begin
               rvld_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready) else $error("ready while busy");
   a_resp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP) |=> rsp_tvalid) else $error("result lost");
   a_free: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (int'(free_ff) <= MAX_FRAMES)) else $error("free count");
`endif
endmodule
`default_nettype wire
